/* rtl/core/fqd_pkg.sv */
`default_nettype none
package fqd_pkg;

  // command codes
  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_INVALID = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic cmp;    // capture compare result
    logic apply;  // update phase
    logic del;    // delete in progress: matches start the shift
    logic load;   // successful enqueue: tail cell takes the token
  } ctl_t;

endpackage
`default_nettype wire

/* rtl/core/fifo_queue_with_delete_top.sv */
`default_nettype none
// Channel   Direction  Handshake         Words
// command   in         start & !busy     cmd, item_value
// result    out        done (one cycle)  status, item_out, length
//
// Every command runs from acceptance to result through these steps: the compare state checks the token in all
// cells at once, the update state resolves the first match along the cell chain and shifts/loads the
// cells, then done is high. busy is high during the first two; the next word may be
// accepted at the edge that ends the done cycle, so a new word is not taken before the last result.
// One result per command.
// rst is synchronous; it empties the queue. The receiver cannot stall.
module fifo_queue_with_delete_top #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] item_value,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] item_out,
  output logic [4:0]  length
);
  import fqd_pkg::*;

  localparam int TOK_BITS = (ITEM_BITS < 32) ? ITEM_BITS : 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  state_t state, state_next;
  ctl_t   ctl;

  logic [1:0]          cmd_q;
  logic [TOK_BITS-1:0] tok_q;
  logic [CNT_W-1:0]    count, count_next;
  logic [1:0]          status_next;
  logic [31:0]         item_out_next;
  logic                head_shift;
  logic                found;

  logic [TOK_BITS-1:0] cell_data [DEPTH];
  logic [DEPTH:0]      chain;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
      tok_q <= item_value[TOK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign head_shift = (state == S_APPLY) && (cmd_q == CMD_DEQ) && (count != '0);
  assign chain[0]   = head_shift;
  assign found      = chain[DEPTH];

  always_comb begin
    state_next    = state;
    ctl           = '0;
    status_next   = STAT_INVALID;
    count_next    = count;
    item_out_next = '0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CMP;
      end
      S_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        ctl.apply  = 1'b1;
        state_next = S_IDLE;
        unique case (cmd_q)
          CMD_ENQ: begin
            if (tok_q == '0) begin
              status_next = STAT_INVALID;
            end else if (count == FULL_CNT) begin
              status_next = STAT_FULL;
            end else begin
              status_next = STAT_OK;
              ctl.load    = 1'b1;
              count_next  = count + 1'b1;
            end
          end
          CMD_DEQ: begin
            if (count == '0) begin
              status_next = STAT_EMPTY;
            end else begin
              status_next   = STAT_OK;
              item_out_next = 32'(cell_data[0]);
              count_next    = count - 1'b1;
            end
          end
          CMD_DEL: begin
            ctl.del = 1'b1;
            if (found) begin
              status_next = STAT_OK;
              count_next  = count - 1'b1;
            end else begin
              status_next = STAT_EMPTY;
            end
          end
          default: status_next = STAT_INVALID;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= (state == S_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      status   <= status_next;
      item_out <= item_out_next;
      length   <= 5'(count_next);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TOK_BITS-1:0] right;
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    fqd_cell #(
      .TOK_BITS(TOK_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .tok       (tok_q),
      .live      (CNT_W'(i) < count),
      .tail      (CNT_W'(i) == count),
      .shift_in  (chain[i]),
      .right_data(right),
      .shift_out (chain[i+1]),
      .data      (cell_data[i])
    );
  end

`ifndef SYNTHESIS
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_APPLY))
    else $error("result strobe without update phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("fill count beyond depth");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CMP))
    else $error("accepted word did not start compare");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_OK && cmd_q == CMD_ENQ) |-> (count == $past(count) + 1'b1))
    else $error("enqueue did not grow queue");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> (count == FULL_CNT))
    else $error("full reported on a queue with room");
`endif

endmodule
`default_nettype wire

/* rtl/core/fqd_cell.sv */
`default_nettype none
module fqd_cell #(
  parameter int TOK_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  fqd_pkg::ctl_t       ctl,
  input  logic [TOK_BITS-1:0] tok,
  input  logic                live,
  input  logic                tail,
  input  logic                shift_in,
  input  logic [TOK_BITS-1:0] right_data,
  output logic                shift_out,
  output logic [TOK_BITS-1:0] data
);
  import fqd_pkg::*;

  logic match;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.cmp) begin
      match <= live && (data == tok);
    end
  end

  // once any cell at or ahead of this one is removed, this one moves up
  assign shift_out = shift_in | (ctl.del & match);

  always_ff @(posedge clk) begin
    if (ctl.apply && shift_out) begin
      data <= right_data;
    end else if (ctl.load && tail) begin
      data <= tok;
    end
  end

endmodule
`default_nettype wire
